>>> rtl/aes128_block_encrypt_top_macros.svh
// assertion macros for the aes-128 encryption block
// used by the checker module only, no other dependencies
`ifndef AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_TOP_MACROS_SVH

// implication checked at every edge outside reset
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/aes128_pkg.sv
// shared constants, types and functions of the aes-128 encryption block
// no dependencies
package aes128_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned BlockBits = 128;
   localparam int unsigned HalfBits  = 64;

   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;

   typedef logic [BlockBits-1:0] block_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
   };

   localparam logic [7:0] RCON [NumRounds] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
   };

   // multiply by x modulo the field polynomial
   function automatic logic [7:0] gf_double(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
   endfunction

   // byte n of the block, byte 0 in the top bits
   function automatic logic [7:0] get_byte(input block_type s, input int unsigned n);
      return s[BlockBits-1-8*n -: 8];
   endfunction

   // next four round key words from the previous four
   function automatic block_type next_round_key(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // one cipher round; the last round skips the column mix
   function automatic block_type cipher_round(input block_type s, input block_type rk,
                                              input logic last);
      block_type t;
      logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[BlockBits-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
         end
      end
      if (!last) begin
         for (int c = 0; c < 4; c++) begin
            a0 = get_byte(t, 4*c);
            a1 = get_byte(t, 4*c+1);
            a2 = get_byte(t, 4*c+2);
            a3 = get_byte(t, 4*c+3);
            d0 = gf_double(a0);
            d1 = gf_double(a1);
            d2 = gf_double(a2);
            d3 = gf_double(a3);
            t[BlockBits-1-32*c -: 32] = {d0 ^ d1 ^ a1 ^ a2 ^ a3, a0 ^ d1 ^ d2 ^ a2 ^ a3,
                                        a0 ^ a1 ^ d2 ^ d3 ^ a3, d0 ^ a0 ^ a1 ^ a2 ^ d3};
         end
      end
      return t ^ rk;
   endfunction

endpackage

>>> rtl/aes128_block_encrypt_top.sv
// aes-128 encryption pipeline top level
// depends on aes128_pkg and aes128_round
// AES-128 (FIPS-197) block encryption with a fully unrolled pipeline. A request
// carries 16 plaintext bytes (text_high holds bytes 0..7, byte 0 in the top
// bits); the response carries the ciphertext in the same layout. One request
// is taken per clock unless an untaken response has backed up every stage;
// there is one input stage (initial key add) and one stage per round, each
// doing one round with its own key expansion step. The key (csr index 0 =
// key_high, index 1 = key_low) is latched with each request, so a key write
// affects only later requests. A stage loads when empty or when the next one
// moves on; an untaken response holds full stages, bubbles are squeezed out.
module aes128_block_encrypt_top #(
   parameter int unsigned Rounds = aes128_pkg::NumRounds
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_text_high,
   input  logic [63:0] req_text_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);

   // key registers
   logic [63:0] key_high_ff, key_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write) begin
         case (csr_index)
            aes128_pkg::CsrKeyHigh: key_high_ff <= csr_data;
            aes128_pkg::CsrKeyLow:  key_low_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // per-stage valid, state and round key; index 0 is the input stage
   logic                  vld   [Rounds+1];
   aes128_pkg::block_type st    [Rounds+1];
   aes128_pkg::block_type rkey  [Rounds+1];
   logic                  stage_adv [Rounds+1];

   // stage i may load when it is empty or the stage after it moves on
   always_comb begin
      stage_adv[Rounds] = !vld[Rounds] || rsp_ready;
      for (int i = Rounds - 1; i >= 0; i--) begin
         stage_adv[i] = !vld[i] || stage_adv[i+1];
      end
   end

   assign req_ready = stage_adv[0];

   // input stage: initial add round key, key captured with the request
   logic                  in_vld_ff;
   aes128_pkg::block_type in_st_ff, in_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (stage_adv[0]) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         in_st_ff  <= {req_text_high, req_text_low} ^ {key_high_ff, key_low_ff};
         in_key_ff <= {key_high_ff, key_low_ff};
      end
   end

   assign vld[0]  = in_vld_ff;
   assign st[0]   = in_st_ff;
   assign rkey[0] = in_key_ff;

   for (genvar g = 1; g <= Rounds; g++) begin : g_round
      aes128_round #(.RoundIdx(g), .LastRound(Rounds)) u_round (
         .clock    (clock),
         .reset    (reset),
         .adv      (stage_adv[g]),
         .valid_in (vld[g-1]),
         .state_in (st[g-1]),
         .key_in   (rkey[g-1]),
         .valid_out(vld[g]),
         .state_out(st[g]),
         .key_out  (rkey[g])
      );
   end

   // last stage doubles as the response register
   assign rsp_valid       = vld[Rounds];
   assign rsp_cipher_high = st[Rounds][127:64];
   assign rsp_cipher_low  = st[Rounds][63:0];

endmodule

>>> rtl/aes128_round.sv
// one registered pipeline stage: cipher round plus key expansion step
// depends on aes128_pkg
module aes128_round #(
   parameter int unsigned RoundIdx  = 1,
   parameter int unsigned LastRound = aes128_pkg::NumRounds
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  valid_in,
   input  aes128_pkg::block_type state_in,
   input  aes128_pkg::block_type key_in,
   output logic                  valid_out,
   output aes128_pkg::block_type state_out,
   output aes128_pkg::block_type key_out
);

   localparam logic Last = (RoundIdx == LastRound);

   aes128_pkg::block_type rk;
   logic                  valid_ff;
   aes128_pkg::block_type state_ff, state_in_n, key_ff;

   assign rk         = aes128_pkg::next_round_key(key_in, aes128_pkg::RCON[RoundIdx-1]);
   assign state_in_n = aes128_pkg::cipher_round(state_in, rk, Last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         state_ff <= state_in_n;
         key_ff   <= rk;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;

endmodule

>>> rtl/aes128_checker.sv
// port-level checker for the aes-128 encryption block, bound to the top level
// depends on aes128_block_encrypt_top_macros.svh
`include "aes128_block_encrypt_top_macros.svh"

module aes128_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_cipher_high,
   input logic [63:0] rsp_cipher_low
);

   logic [127:0] rsp_data;

   assign rsp_data = {rsp_cipher_high, rsp_cipher_low};

   // a held response keeps its data
   `AES_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // a free output side never blocks requests
   `AES_ASSERT_IMPL(a_ready_free, clock, reset, rsp_ready, req_ready)
   // an empty output register means the pipe can take a request
   `AES_ASSERT_IMPL(a_ready_empty, clock, reset, !rsp_valid, req_ready)
   // no response right after reset release
   `AES_ASSERT_NEXT(a_no_early, clock, 1'b0, reset, !rsp_valid)

endmodule

bind aes128_block_encrypt_top aes128_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cipher_high(rsp_cipher_high),
   .rsp_cipher_low (rsp_cipher_low)
);

>>> tb/testbench.sv
// self-checking testbench for the aes-128 block encryption top level
// depends on aes128_pkg and aes128_block_encrypt_top
`timescale 1ns / 100ps

module testbench;

   localparam int unsigned TimeoutCycles = 400000;
   localparam int unsigned DrainCycles   = 40;

   typedef struct packed {
      logic [63:0] text_high;
      logic [63:0] text_low;
   } plain_block_type;

   typedef struct packed {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
   } cipher_block_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_text_high;
   logic [63:0] req_text_low;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        csr_write;
   logic [0:0]  csr_index;
   logic [63:0] csr_data;

   aes128_block_encrypt_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_text_high  (req_text_high),
      .req_text_low   (req_text_low),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_cipher_high(rsp_cipher_high),
      .rsp_cipher_low (rsp_cipher_low),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // 20 ns period
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // key mirror, updated when a key register is written
   logic [63:0] key_high_mirror;
   logic [63:0] key_low_mirror;

   plain_block_type  pending_plain[$];
   cipher_block_type expected_cipher[$];

   int unsigned sender_idle_pct;
   int unsigned receiver_stall_pct;
   int unsigned mismatch_count;
   int unsigned cycle_count;

   // forward s-box built from the field inverse and the affine map
   function automatic logic [7:0] sub_byte(input logic [7:0] b);
      logic [7:0] inv;
      logic [7:0] p;
      logic [7:0] a;
      logic [7:0] r;
      // multiplicative inverse by brute force, then the affine map
      inv = 8'h00;
      for (int x = 1; x < 256; x++) begin
         p = 8'h00;
         a = x[7:0];
         for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
         end
         if (p == 8'h01) inv = x[7:0];
      end
      r = 8'h63;
      for (int i = 0; i < 8; i++) begin
         r[i] = r[i] ^ inv[i] ^ inv[(i+4)%8] ^ inv[(i+5)%8] ^ inv[(i+6)%8] ^ inv[(i+7)%8];
      end
      return r;
   endfunction

   logic [7:0] sbox_table [256];

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
   endfunction

   // full encryption of one block under the mirrored key
   function automatic cipher_block_type encrypt_block(input plain_block_type pt,
                                                      input logic [63:0] kh,
                                                      input logic [63:0] kl);
      logic [31:0]  w [44];
      logic [7:0]   st [16];
      logic [7:0]   tmp [16];
      logic [127:0] key;
      logic [127:0] blk;
      logic [31:0]  t;
      logic [7:0]   rc;
      logic [7:0]   a0, a1, a2, a3;
      cipher_block_type ct;
      key = {kh, kl};
      blk = {pt.text_high, pt.text_low};
      for (int i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {sbox_table[t[31:24]] ^ rc, sbox_table[t[23:16]],
                 sbox_table[t[15:8]], sbox_table[t[7:0]]};
            rc = xtime(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int n = 0; n < 16; n++) st[n] = blk[127-8*n -: 8];
      for (int rnd = 0; rnd <= 10; rnd++) begin
         if (rnd > 0) begin
            // sub bytes and shift rows
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  tmp[4*c+r] = sbox_table[st[4*((c+r)%4)+r]];
            st = tmp;
            if (rnd != 10) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = st[4*c];
                  a1 = st[4*c+1];
                  a2 = st[4*c+2];
                  a3 = st[4*c+3];
                  st[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                  st[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                  st[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                  st[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
               end
            end
         end
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               st[4*c+r] = st[4*c+r] ^ w[4*rnd+c][31-8*r -: 8];
      end
      for (int n = 0; n < 8; n++) begin
         ct.cipher_high[63-8*n -: 8] = st[n];
         ct.cipher_low[63-8*n -: 8]  = st[8+n];
      end
      return ct;
   endfunction

   // driver: holds a request until it is taken, idles at random between requests
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // the expectation is formed at acceptance with the key in force then
         if (req_valid && req_ready) begin
            expected_cipher.push_back(encrypt_block({req_text_high, req_text_low},
                                                    key_high_mirror, key_low_mirror));
         end
         if (!req_valid || req_ready) begin
            if (pending_plain.size() > 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
               plain_block_type nxt;
               nxt = pending_plain.pop_front();
               req_valid     <= 1'b1;
               req_text_high <= nxt.text_high;
               req_text_low  <= nxt.text_low;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random backpressure, compare every response with the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cipher.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response %h %h", rsp_cipher_high, rsp_cipher_low);
            end else begin
               cipher_block_type exp_ct;
               exp_ct = expected_cipher.pop_front();
               if (rsp_cipher_high !== exp_ct.cipher_high ||
                   rsp_cipher_low !== exp_ct.cipher_low) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("cipher mismatch: expected %h %h, got %h %h",
                              exp_ct.cipher_high, exp_ct.cipher_low,
                              rsp_cipher_high, rsp_cipher_low);
               end
            end
         end
         rsp_ready <= ($urandom_range(99, 0) >= receiver_stall_pct);
      end
   end

   // hard limit on run length
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TimeoutCycles) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_key(input logic [0:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == aes128_pkg::CsrKeyHigh) key_high_mirror = value;
      else key_low_mirror = value;
   endtask

   task automatic set_key(input logic [63:0] kh, input logic [63:0] kl);
      write_key(aes128_pkg::CsrKeyHigh, kh);
      write_key(aes128_pkg::CsrKeyLow, kl);
   endtask

   // wait until every request sent so far has its response back
   task automatic drain_pipeline();
      while (pending_plain.size() > 0 || req_valid || expected_cipher.size() > 0)
         @(posedge clock);
   endtask

   task automatic queue_random(input int unsigned count);
      plain_block_type pb;
      for (int i = 0; i < count; i++) begin
         pb.text_high = {$urandom, $urandom};
         pb.text_low  = {$urandom, $urandom};
         pending_plain.push_back(pb);
      end
   endtask

   initial begin
      logic [63:0] ones;
      ones = '1;
      for (int i = 0; i < 256; i++) sbox_table[i] = sub_byte(i[7:0]);
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_text_high      = '0;
      req_text_low       = '0;
      rsp_ready          = 1'b0;
      csr_write          = 1'b0;
      csr_index          = aes128_pkg::CsrKeyHigh;
      csr_data           = '0;
      key_high_mirror    = '0;
      key_low_mirror     = '0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      mismatch_count     = 0;
      cycle_count        = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: zero reset key, standard vector, all-ones key, second standard vector
      pending_plain.push_back({64'h0, 64'h0});
      pending_plain.push_back({ones, ones});
      drain_pipeline();
      set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
      pending_plain.push_back({64'h0011223344556677, 64'h8899aabbccddeeff});
      pending_plain.push_back({64'h0, 64'h0});
      pending_plain.push_back({ones, ones});
      pending_plain.push_back({64'h8000000000000000, 64'h0});
      pending_plain.push_back({64'h0, 64'h1});
      drain_pipeline();
      set_key(ones, ones);
      pending_plain.push_back({64'h0, 64'h0});
      pending_plain.push_back({ones, ones});
      pending_plain.push_back({64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
      drain_pipeline();
      set_key(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c);
      pending_plain.push_back({64'h3243f6a8885a308d, 64'h313198a2e0370734});
      drain_pipeline();

      // random phases: no idling, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         sender_idle_pct    = (ph == 1) ? 56 : (ph == 3) ? 37 : 0;
         receiver_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 37 : 0;
         set_key({$urandom, $urandom}, {$urandom, $urandom});
         queue_random(56);
         drain_pipeline();
         set_key({$urandom, $urandom}, {$urandom, $urandom});
         queue_random(56);
         drain_pipeline();
      end
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && expected_cipher.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
